/* hdl/xcpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcpd_pkg
// Shared types and constants of the XOR-checked packet deframer.
// ----------------------------------------------------------------------------
package xcpd_pkg;

  // Receive phase of the frame parser
  typedef enum logic [2:0] {
    PhHunt    = 3'd0,
    PhCode    = 3'd1,
    PhLenLo   = 3'd2,
    PhLenHi   = 3'd3,
    PhPayload = 3'd4,
    PhCheck   = 3'd5
  } phase_e;

  // Event reported with every received byte
  typedef enum logic [2:0] {
    EvIdle    = 3'd0,
    EvHeader  = 3'd1,
    EvPayload = 3'd2,
    EvGood    = 3'd3,
    EvBadSum  = 3'd4,
    EvBadLen  = 3'd5,
    EvBadCode = 3'd6
  } event_e;

  // Register indexes (byte address / 4)
  localparam logic [2:0] RegStartByte    = 3'd0;
  localparam logic [2:0] RegCodeIdentify = 3'd1;
  localparam logic [2:0] RegCodeDump     = 3'd2;
  localparam logic [2:0] RegCodeAck      = 3'd3;
  localparam logic [2:0] RegCodeNack     = 3'd4;
  localparam logic [2:0] RegIdentifyLen  = 3'd5;

  localparam logic [15:0] NackLength    = 16'd2;
  localparam logic [15:0] DumpMinLength = 16'd5;

  typedef struct packed {
    event_e      event_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_code;
    logic [15:0] frame_length;
  } result_t;

endpackage

/* hdl/xcpd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcpd_rx_if / xcpd_ev_if
// Valid/ready channels of the deframer: received bytes in, events out.
// ----------------------------------------------------------------------------
interface xcpd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xcpd_ev_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic [7:0]  frame_code;
  logic [15:0] frame_length;

  modport source (output valid, output event_kind, output payload_byte,
                  output payload_index, output frame_code, output frame_length,
                  input ready);
  modport sink   (input valid, input event_kind, input payload_byte,
                  input payload_index, input frame_code, input frame_length,
                  output ready);
endinterface

/* hdl/xor_checked_packet_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_packet_deframer
// Parses start/code/length/payload/XOR-checksum frames from a byte stream
// and reports one event per received byte.
// ----------------------------------------------------------------------------
// Pipeline: each byte passes an input register, then a result register.
// Throughput: 1 byte per cycle unless the event output stalls; the parser
// state advances with each byte that moves into the result register.
// Reset: asynchronous, active low; parser returns to hunting, registers take
// their default values, both pipeline stages empty.
module xor_checked_packet_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  xcpd_rx_if.sink     rx_i,
  xcpd_ev_if.source   ev_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import xcpd_pkg::*;

  // Configuration registers
  logic [7:0]  start_byte_q, code_identify_q, code_dump_q, code_ack_q, code_nack_q;
  logic [15:0] identify_length_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  // Pipeline
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        out_valid_q;
  result_t     out_q;
  result_t     res_d;
  logic        s2_free, s1_adv;

  // Parser state
  phase_e      phase_q, phase_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  code_q, code_d;
  logic [15:0] exp_len_q, exp_len_d;
  logic [15:0] count_q, count_d;
  logic [15:0] count_inc;
  logic        code_known, len_fits;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q      <= 8'd170;
      code_identify_q   <= 8'd1;
      code_dump_q       <= 8'd2;
      code_ack_q        <= 8'd3;
      code_nack_q       <= 8'd4;
      identify_length_q <= 16'd16;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegStartByte:    start_byte_q      <= pwdata[7:0];
        RegCodeIdentify: code_identify_q   <= pwdata[7:0];
        RegCodeDump:     code_dump_q       <= pwdata[7:0];
        RegCodeAck:      code_ack_q        <= pwdata[7:0];
        RegCodeNack:     code_nack_q       <= pwdata[7:0];
        RegIdentifyLen:  identify_length_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegStartByte:    prdata = {24'd0, start_byte_q};
      RegCodeIdentify: prdata = {24'd0, code_identify_q};
      RegCodeDump:     prdata = {24'd0, code_dump_q};
      RegCodeAck:      prdata = {24'd0, code_ack_q};
      RegCodeNack:     prdata = {24'd0, code_nack_q};
      RegIdentifyLen:  prdata = {16'd0, identify_length_q};
      default:         prdata = 32'd0;
    endcase
  end

  // Handshake: the result register frees when empty or taken downstream
  assign s2_free    = !out_valid_q || ev_o.ready;
  assign s1_adv     = s1_valid_q && s2_free;
  assign rx_i.ready = !s1_valid_q || s2_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_i.ready) begin
        s1_valid_q <= rx_i.valid;
      end
      if (s2_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      s1_byte_q <= rx_i.rx_byte;
    end
    if (s1_adv) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      xor_q     <= 8'd0;
      code_q    <= 8'd0;
      exp_len_q <= 16'd0;
      count_q   <= 16'd0;
    end else if (s1_adv) begin
      phase_q   <= phase_d;
      xor_q     <= xor_d;
      code_q    <= code_d;
      exp_len_q <= exp_len_d;
      count_q   <= count_d;
    end
  end

  // Code decode; overlapping codes resolve identify, dump, ack, nack
  assign code_known = (s1_byte_q == code_identify_q) || (s1_byte_q == code_dump_q) ||
                      (s1_byte_q == code_ack_q) || (s1_byte_q == code_nack_q);

  always_comb begin
    if (code_q == code_identify_q) begin
      len_fits = (count_q == identify_length_q);
    end else if (code_q == code_dump_q) begin
      len_fits = (count_q >= DumpMinLength);
    end else if (code_q == code_ack_q) begin
      len_fits = (count_q == 16'd0);
    end else if (code_q == code_nack_q) begin
      len_fits = (count_q == NackLength);
    end else begin
      len_fits = 1'b0;
    end
  end

  assign count_inc = count_q + 16'd1;

  // Next state
  always_comb begin
    phase_d   = phase_q;
    xor_d     = xor_q;
    code_d    = code_q;
    exp_len_d = exp_len_q;
    count_d   = count_q;
    unique case (phase_q)
      PhCode: begin
        if (code_known) begin
          code_d  = s1_byte_q;
          xor_d   = xor_q ^ s1_byte_q;
          phase_d = PhLenLo;
        end else begin
          phase_d = PhHunt;
        end
      end
      PhLenLo: begin
        exp_len_d = {8'd0, s1_byte_q};
        xor_d     = xor_q ^ s1_byte_q;
        phase_d   = PhLenHi;
      end
      PhLenHi: begin
        exp_len_d = {s1_byte_q, exp_len_q[7:0]};
        count_d   = 16'd0;
        xor_d     = xor_q ^ s1_byte_q;
        phase_d   = ({s1_byte_q, exp_len_q[7:0]} != 16'd0) ? PhPayload : PhCheck;
      end
      PhPayload: begin
        count_d = count_inc;
        xor_d   = xor_q ^ s1_byte_q;
        if (count_inc == exp_len_q) begin
          phase_d = PhCheck;
        end
      end
      PhCheck: begin
        phase_d = PhHunt;
      end
      default: begin
        // hunting, and any unused phase code
        phase_d = PhHunt;
        if (s1_byte_q == start_byte_q) begin
          phase_d   = PhCode;
          xor_d     = s1_byte_q;
          code_d    = 8'd0;
          exp_len_d = 16'd0;
          count_d   = 16'd0;
        end
      end
    endcase
  end

  // Result of this byte
  always_comb begin
    res_d = '{event_kind: EvIdle, payload_byte: 8'd0, payload_index: 16'd0,
              frame_code: 8'd0, frame_length: 16'd0};
    unique case (phase_q)
      PhCode: begin
        res_d.frame_code = s1_byte_q;
        res_d.event_kind = code_known ? EvHeader : EvBadCode;
      end
      PhLenLo: begin
        res_d.event_kind = EvHeader;
        res_d.frame_code = code_q;
      end
      PhLenHi: begin
        res_d.event_kind   = EvHeader;
        res_d.frame_code   = code_q;
        res_d.frame_length = {s1_byte_q, exp_len_q[7:0]};
      end
      PhPayload: begin
        res_d.event_kind    = EvPayload;
        res_d.payload_byte  = s1_byte_q;
        res_d.payload_index = count_q;
        res_d.frame_code    = code_q;
        res_d.frame_length  = exp_len_q;
      end
      PhCheck: begin
        if (xor_q != s1_byte_q) begin
          res_d.event_kind = EvBadSum;
        end else if (len_fits) begin
          res_d.event_kind = EvGood;
        end else begin
          res_d.event_kind = EvBadLen;
        end
        res_d.frame_code   = code_q;
        res_d.frame_length = exp_len_q;
      end
      default: begin
        if (s1_byte_q == start_byte_q) begin
          res_d.event_kind = EvHeader;
        end
      end
    endcase
  end

  assign ev_o.valid         = out_valid_q;
  assign ev_o.event_kind    = out_q.event_kind;
  assign ev_o.payload_byte  = out_q.payload_byte;
  assign ev_o.payload_index = out_q.payload_index;
  assign ev_o.frame_code    = out_q.frame_code;
  assign ev_o.frame_length  = out_q.frame_length;

endmodule

/* tb/xor_checked_packet_deframer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_packet_deframer_test
// Self-checking bench for the frame deframer. Builds start/code/length/
// payload/checksum frames (good, corrupted, truncated, unknown code) mixed
// with line noise, tracks the parser in a cycle-free predictor and checks
// every event field against it under random sender gaps and receiver stalls.
// Runs several register settings, including overlapping codes and a payload
// longer than 255 bytes.
// ----------------------------------------------------------------------------
module xor_checked_packet_deframer_test;
  import xcpd_pkg::*;

  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;
  localparam int HoldCycles = 80;

  // Predicts one event per received byte and holds the events still due
  class frame_event_tracker;
    logic [7:0]  start_b, code_ident, code_dump, code_ack, code_nack;
    logic [15:0] ident_len;
    phase_e      ph;
    logic [7:0]  xor_acc, code_held;
    logic [15:0] len_want, len_seen;
    result_t     events_due[$];
    int          errors, bytes_in;
    int          hits[7];

    function new();
      start_b    = 8'd170;
      code_ident = 8'd1;
      code_dump  = 8'd2;
      code_ack   = 8'd3;
      code_nack  = 8'd4;
      ident_len  = 16'd16;
      ph         = PhHunt;
      xor_acc    = '0;
      code_held  = '0;
      len_want   = '0;
      len_seen   = '0;
      errors     = 0;
      bytes_in   = 0;
      foreach (hits[k]) hits[k] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        RegStartByte:    start_b    = value[7:0];
        RegCodeIdentify: code_ident = value[7:0];
        RegCodeDump:     code_dump  = value[7:0];
        RegCodeAck:      code_ack   = value[7:0];
        RegCodeNack:     code_nack  = value[7:0];
        RegIdentifyLen:  ident_len  = value[15:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      result_t r;
      bit      fits;
      r = '0;
      r.event_kind = EvIdle;
      bytes_in++;
      case (ph)
        PhCode: begin
          if (b == code_ident || b == code_dump || b == code_ack || b == code_nack) begin
            code_held = b;
            xor_acc ^= b;
            ph = PhLenLo;
            r.event_kind = EvHeader;
          end else begin
            // rejected code is not looked at again as a start byte
            ph = PhHunt;
            r.event_kind = EvBadCode;
          end
          r.frame_code = b;
        end
        PhLenLo: begin
          len_want = {8'h00, b};
          xor_acc ^= b;
          ph = PhLenHi;
          r.event_kind = EvHeader;
          r.frame_code = code_held;
        end
        PhLenHi: begin
          len_want[15:8] = b;
          len_seen = '0;
          xor_acc ^= b;
          ph = (len_want != 16'd0) ? PhPayload : PhCheck;
          r.event_kind = EvHeader;
          r.frame_code = code_held;
          r.frame_length = len_want;
        end
        PhPayload: begin
          r.event_kind = EvPayload;
          r.payload_byte = b;
          r.payload_index = len_seen;
          len_seen++;
          xor_acc ^= b;
          if (len_seen == len_want) ph = PhCheck;
          r.frame_code = code_held;
          r.frame_length = len_want;
        end
        PhCheck: begin
          // first matching code wins when code registers overlap
          if (code_held == code_ident) fits = (len_seen == ident_len);
          else if (code_held == code_dump) fits = (len_seen >= DumpMinLength);
          else if (code_held == code_ack) fits = (len_seen == 16'd0);
          else fits = (code_held == code_nack) && (len_seen == NackLength);
          if (xor_acc != b) r.event_kind = EvBadSum;
          else if (fits) r.event_kind = EvGood;
          else r.event_kind = EvBadLen;
          ph = PhHunt;
          r.frame_code = code_held;
          r.frame_length = len_want;
        end
        default: begin
          ph = PhHunt;
          if (b == start_b) begin
            ph = PhCode;
            xor_acc = b;
            code_held = '0;
            len_want = '0;
            len_seen = '0;
            r.event_kind = EvHeader;
          end
        end
      endcase
      events_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        errors++;
      end
    endfunction

    function void check_event(result_t got);
      result_t want;
      if (events_due.size() == 0) begin
        $error("event_kind: expected no transfer, got %0d", got.event_kind);
        errors++;
        return;
      end
      want = events_due.pop_front();
      hits[int'(want.event_kind)]++;
      compare_field("event_kind", 16'(want.event_kind), 16'(got.event_kind));
      compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
      compare_field("payload_index", want.payload_index, got.payload_index);
      compare_field("frame_code", 16'(want.frame_code), 16'(got.frame_code));
      compare_field("frame_length", want.frame_length, got.frame_length);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  xcpd_rx_if rx_bus();
  xcpd_ev_if ev_bus();

  frame_event_tracker tracker = new();

  int burst_left;
  int bytes_sent;
  bit hold_request;

  xor_checked_packet_deframer uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .rx_i    (rx_bus),
    .ev_o    (ev_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("xor_checked_packet_deframer verification failed");
    $finish;
  end

  // Receiver: random stall patterns, plus a long hold-off on request
  initial begin : receiver
    int   hold_left;
    int   mode;
    int   mode_left;
    int   tick;
    logic rdy;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    tick = 0;
    ev_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        case (mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 4) != 0);
          2: rdy = ((tick % 4) != 3);
          default: rdy = 1'($urandom_range(0, 1));
        endcase
      end
      ev_bus.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    result_t seen;
    if (rst_n) begin
      if (rx_bus.valid && rx_bus.ready) tracker.note_byte(rx_bus.rx_byte);
      if (ev_bus.valid && ev_bus.ready) begin
        seen.event_kind    = event_e'(ev_bus.event_kind);
        seen.payload_byte  = ev_bus.payload_byte;
        seen.payload_index = ev_bus.payload_index;
        seen.frame_code    = ev_bus.frame_code;
        seen.frame_length  = ev_bus.frame_length;
        tracker.check_event(seen);
      end
    end
  end

  // One byte transfer; the sender runs in bursts with random gaps
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        rx_bus.valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    @(posedge clk);
    while (!rx_bus.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Full frame, optionally with a spoiled checksum or cut off in the payload
  task automatic send_frame(input logic [7:0] code, input logic [15:0] len,
                            input bit spoil, input bit cut);
    logic [7:0] sum;
    logic [7:0] data;
    int         stop;
    bit         start_ok;
    sum = tracker.start_b ^ code ^ len[7:0] ^ len[15:8];
    stop = (cut && len != 16'd0) ? $urandom_range(0, len - 1) : len;
    start_ok = ($urandom_range(0, 7) == 0);
    send_byte(tracker.start_b);
    send_byte(code);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    for (int i = 0; i < stop; i++) begin
      data = 8'($urandom);
      // keep stray start bytes rare so frames mostly stay aligned
      if (!start_ok && data == tracker.start_b) data = ~data;
      sum ^= data;
      send_byte(data);
    end
    if (!cut) begin
      if (spoil) sum ^= 8'($urandom_range(1, 255));
      send_byte(sum);
    end
  endtask

  task automatic send_random_unit();
    int          pick;
    int          kind;
    logic [7:0]  code;
    logic [7:0]  data;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 4)) begin
        data = 8'($urandom);
        if (data == tracker.start_b) data = ~data;
        send_byte(data);
      end
    end else begin
      kind = $urandom_range(0, 4);
      case (kind)
        0: begin
          code = tracker.code_ident;
          len = (tracker.ident_len <= 16'd40) ? tracker.ident_len
                                              : 16'($urandom_range(0, 40));
        end
        1: begin
          code = tracker.code_dump;
          len = 16'($urandom_range(5, 24));
        end
        2: begin
          code = tracker.code_ack;
          len = 16'd0;
        end
        3: begin
          code = tracker.code_nack;
          len = NackLength;
        end
        default: begin
          code = 8'($urandom);
          len = 16'($urandom_range(0, 8));
        end
      endcase
      if ($urandom_range(0, 3) == 0) len = 16'($urandom_range(0, 12));
      send_frame(code, len, ($urandom_range(0, 5) == 0), (pick < 17));
    end
  endtask

  // Feed filler until the parser is back to hunting; zero for length bytes,
  // else a byte that is neither a start byte nor a known code
  task automatic flush_frame();
    logic [7:0] fill;
    forever begin
      @(negedge clk);
      rx_bus.valid <= 1'b0;
      if (tracker.ph == PhHunt) break;
      if (tracker.ph == PhLenLo || tracker.ph == PhLenHi) begin
        fill = 8'h00;
      end else begin
        fill = ~tracker.start_b;
        while (fill == tracker.start_b || fill == tracker.code_ident ||
               fill == tracker.code_dump || fill == tracker.code_ack ||
               fill == tracker.code_nack) fill++;
      end
      send_byte(fill);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    rx_bus.valid <= 1'b0;
    while (tracker.events_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int target;
    target = bytes_sent + count;
    while (bytes_sent < target) send_random_unit();
    flush_frame();
    wait_idle();
  endtask

  // Upper data bits are random; the block keeps only the register width
  task automatic apb_write(input logic [2:0] idx, input logic [15:0] value);
    logic [31:0] wdata;
    wdata = $urandom;
    if (idx == RegIdentifyLen) wdata[15:0] = value;
    else wdata[7:0] = value[7:0];
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, wdata);
  endtask

  task automatic load_config(input logic [7:0] start, input logic [7:0] ident,
                             input logic [7:0] dump, input logic [7:0] ack,
                             input logic [7:0] nack, input logic [15:0] id_len);
    apb_write(RegStartByte, {8'd0, start});
    apb_write(RegCodeIdentify, {8'd0, ident});
    apb_write(RegCodeDump, {8'd0, dump});
    apb_write(RegCodeAck, {8'd0, ack});
    apb_write(RegCodeNack, {8'd0, nack});
    apb_write(RegIdentifyLen, id_len);
  endtask

  initial begin
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = 8'h00;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rst_n          = 1'b0;
    burst_left     = 0;
    bytes_sent     = 0;
    hold_request   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: noise, good ack/nack, unknown code, start byte as code,
    // dump too short, ack with bad checksum
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(tracker.code_ack, 16'd0, 1'b0, 1'b0);
    send_frame(tracker.code_nack, NackLength, 1'b0, 1'b0);
    send_byte(tracker.start_b);
    send_byte(8'h7F);
    send_byte(tracker.start_b);
    send_byte(tracker.start_b);
    send_frame(tracker.code_dump, 16'd1, 1'b0, 1'b0);
    send_frame(tracker.code_ack, 16'd0, 1'b1, 1'b0);
    wait_idle();

    // Receiver holds off while the sender keeps pushing, no gaps
    hold_request = 1'b1;
    burst_left = 300;
    run_random(150);
    run_random(150);

    load_config(8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 16'd0);
    apb_write(RegSpareLo, 16'hFFFF);
    apb_write(RegSpareHi, 16'h5A5A);
    repeat (4) @(posedge clk);
    run_random(260);

    // All codes equal: every frame with that code is judged as identify
    load_config(8'hFF, 8'h55, 8'h55, 8'h55, 8'h55, 16'd7);
    repeat (4) @(posedge clk);
    run_random(220);

    // Length with a nonzero high byte
    load_config(8'hAA, 8'h01, 8'h02, 8'h03, 8'h04, 16'd260);
    repeat (4) @(posedge clk);
    send_frame(tracker.code_ident, 16'd260, 1'b0, 1'b0);
    wait_idle();
    run_random(80);

    load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                16'($urandom_range(0, 30)));
    repeat (4) @(posedge clk);
    run_random(180);

    $display("Covered %0d bytes over five register settings, incl. a 260-byte payload.",
             tracker.bytes_in);
    $display("Events: %0d idle, %0d header, %0d payload, %0d good,",
             tracker.hits[EvIdle], tracker.hits[EvHeader], tracker.hits[EvPayload],
             tracker.hits[EvGood]);
    $display("        %0d bad sum, %0d bad len, %0d bad code",
             tracker.hits[EvBadSum], tracker.hits[EvBadLen], tracker.hits[EvBadCode]);
    if (tracker.errors == 0) begin
      $display("xor_checked_packet_deframer verification clean");
    end else begin
      $display("xor_checked_packet_deframer verification failed");
    end
    $finish;
  end

endmodule
